[rtl/fpcs_pkg.sv]
// Shared types and constants for the first-person camera step block.
// Used by fpcs_sine, fpcs_mul and the first_person_camera_step top level.
`default_nettype none

package fpcs_pkg;

    // Angles are in 1/64 degree.
    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int PITCH_LIMIT  = 3840;

    // pi/2 in Q2.30, used to build the quarter-wave sine table.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Speed is Q2.24, and 1.0 is its limit in both directions.
    localparam int SPEED_ONE  = 16777216;
    localparam int ROUND_HALF = 4194304;
    localparam int TERM_SHIFT = 23;

    localparam int ANGLE_W = 17;
    localparam int TRIG_W  = 16;
    localparam int SPEED_W = 26;
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = 43;
    localparam int STEP_W  = 4;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Sequencer steps of a tick.
    localparam logic [STEP_W-1:0] STEP_SIN_YAW   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_COS_YAW   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SIN_PITCH = 4'd2;
    localparam logic [STEP_W-1:0] STEP_Z_FWD     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_X_FWD     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_X_STRAFE  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_Z_STRAFE  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_RESULT    = 4'd11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        TRIG_SIN_YAW,
        TRIG_COS_YAW,
        TRIG_SIN_PITCH
    } trig_sel_t;

    typedef enum logic [1:0] {
        MUL_SPEED_FWD,
        MUL_SPEED_STRAFE,
        MUL_STEP_X,
        MUL_STEP_Z
    } mul_sel_t;

    typedef struct packed {
        logic      valid;
        trig_sel_t sel;
    } trig_req_t;

    typedef struct packed {
        logic     valid;
        mul_sel_t sel;
    } mul_req_t;

endpackage

`default_nettype wire

[rtl/fpcs_sine.sv]
// Five-stage pipelined Q1.15 sine lookup over a quarter-wave constant table.
// Depends on fpcs_pkg for angle constants, widths and the request tag struct.
`default_nettype none

module fpcs_sine
    import fpcs_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  trig_req_t                 req_in,
    input  logic signed [ANGLE_W-1:0] angle,
    output trig_req_t                 rsp_out,
    output logic signed [TRIG_W-1:0]  value
);

    localparam int IDX_W      = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int V_W        = $clog2(QUARTER_TURN * (SINE_TABLE_ENTRIES + 1));
    localparam int W_W        = V_W - 7;
    localparam int RECIP_DIV  = QUARTER_TURN / 128;
    localparam int RECIP_M    = (1 << 24) / RECIP_DIV;
    localparam int P_W        = W_W + 19;
    localparam int K_W        = P_W - 24;
    localparam int HALF_QT    = QUARTER_TURN / 2;

    localparam logic signed [ANGLE_W-1:0] TURN_A = ANGLE_W'(FULL_TURN);

    // Seven-term Taylor series in Q2.30, rounded to Q1.15 and saturated.
    function automatic logic [14:0] taylor_q15(input logic [63:0] x);
        logic [63:0]        m1;
        logic [63:0]        m2;
        logic [63:0]        m3;
        logic [63:0]        m4;
        logic [63:0]        m5;
        logic [63:0]        m6;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        m1  = ((((x * x) >> 30) * x) >> 30) / 64'd6;
        m2  = ((((m1 * x) >> 30) * x) >> 30) / 64'd20;
        m3  = ((((m2 * x) >> 30) * x) >> 30) / 64'd42;
        m4  = ((((m3 * x) >> 30) * x) >> 30) / 64'd72;
        m5  = ((((m4 * x) >> 30) * x) >> 30) / 64'd110;
        m6  = ((((m5 * x) >> 30) * x) >> 30) / 64'd156;
        sum = signed'(x) - signed'(m1) + signed'(m2) - signed'(m3)
            + signed'(m4) - signed'(m5) + signed'(m6);
        if (sum < 0) begin
            sum = '0;
        end
        rnd = (unsigned'(sum) + 64'd16384) >> 15;
        if (rnd > 64'd32767) begin
            rnd = 64'd32767;
        end
        return rnd[14:0];
    endfunction

    logic [14:0] rom [0:SINE_TABLE_ENTRIES];

    for (genvar gi = 0; gi <= SINE_TABLE_ENTRIES; gi++) begin : g_rom
        localparam logic [63:0] X_Q30 = (HALF_PI_Q30 * 64'(gi)) / 64'(SINE_TABLE_ENTRIES);
        localparam logic [14:0] ENTRY = taylor_q15(X_Q30);
        assign rom[gi] = ENTRY;
    end

    trig_req_t req1_reg, req2_reg, req3_reg, req4_reg, rsp_reg;

    logic [1:0]              quad1_reg, quad2_reg, quad3_reg;
    logic [12:0]             r1_reg;
    logic [V_W-1:0]          v2_reg;
    logic [W_W-1:0]          w3_reg;
    logic [P_W-1:0]          prod3_reg;
    logic [IDX_W-1:0]        idx4_reg;
    logic                    neg4_reg;
    logic signed [TRIG_W-1:0] value_reg;

    logic signed [ANGLE_W-1:0] wrapped;
    logic [14:0]               turn_pos;
    logic [1:0]                quad;
    logic [12:0]               rem_angle;
    logic [V_W-1:0]            v_next;
    logic [W_W-1:0]            w_next;
    logic [P_W-1:0]            prod_next;
    logic [K_W-1:0]            k0;
    logic [W_W-1:0]            k_rem;
    logic [IDX_W-1:0]          k_fix;
    logic [IDX_W-1:0]          idx_next;
    logic [14:0]               mag;

    // Stage 1: reduce into one turn, then find the quadrant and the angle within it.
    always_comb begin
        if (angle < 0) begin
            wrapped = angle + TURN_A;
        end else if (angle >= TURN_A) begin
            wrapped = angle - TURN_A;
        end else begin
            wrapped = angle;
        end
        turn_pos = wrapped[14:0];
        if (turn_pos >= 15'(3 * QUARTER_TURN)) begin
            quad      = 2'd3;
            rem_angle = 13'(turn_pos - 15'(3 * QUARTER_TURN));
        end else if (turn_pos >= 15'(2 * QUARTER_TURN)) begin
            quad      = 2'd2;
            rem_angle = 13'(turn_pos - 15'(2 * QUARTER_TURN));
        end else if (turn_pos >= 15'(QUARTER_TURN)) begin
            quad      = 2'd1;
            rem_angle = 13'(turn_pos - 15'(QUARTER_TURN));
        end else begin
            quad      = 2'd0;
            rem_angle = turn_pos[12:0];
        end
    end

    // Stages 2 to 4: index = round(r * N / 5760). The division runs as >> 7 and
    // a floor reciprocal multiply by 1/45, which is low by at most one.
    always_comb begin
        v_next    = V_W'(32'(r1_reg) * 32'(SINE_TABLE_ENTRIES) + 32'(HALF_QT));
        w_next    = v2_reg[V_W-1:7];
        prod_next = P_W'(64'(w_next) * 64'(RECIP_M));
        k0        = prod3_reg[P_W-1:24];
        k_rem     = W_W'(w3_reg - W_W'(32'(k0) * 32'(RECIP_DIV)));
        k_fix     = IDX_W'(k0) + IDX_W'(k_rem >= W_W'(RECIP_DIV));
        idx_next  = quad3_reg[0] ? IDX_W'(SINE_TABLE_ENTRIES) - k_fix : k_fix;
        mag       = rom[idx4_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req1_reg <= '0;
            req2_reg <= '0;
            req3_reg <= '0;
            req4_reg <= '0;
            rsp_reg  <= '0;
        end else begin
            req1_reg <= req_in;
            req2_reg <= req1_reg;
            req3_reg <= req2_reg;
            req4_reg <= req3_reg;
            rsp_reg  <= req4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        quad1_reg <= quad;
        r1_reg    <= rem_angle;
        quad2_reg <= quad1_reg;
        v2_reg    <= v_next;
        quad3_reg <= quad2_reg;
        w3_reg    <= w_next;
        prod3_reg <= prod_next;
        idx4_reg  <= idx_next;
        neg4_reg  <= quad3_reg[1];
        value_reg <= neg4_reg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end

    assign rsp_out = rsp_reg;
    assign value   = value_reg;

endmodule

`default_nettype wire

[rtl/fpcs_mul.sv]
// Shared signed multiplier with a registered product and a tag that follows it.
// Depends on fpcs_pkg for operand widths and the mul_req_t tag struct.
`default_nettype none

module fpcs_mul
    import fpcs_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mul_req_t                  req_in,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output mul_req_t                  rsp_out,
    output logic signed [MUL_P_W-1:0] product
);

    mul_req_t                  rsp_reg;
    logic signed [MUL_P_W-1:0] product_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_reg <= '0;
        end else begin
            rsp_reg <= req_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_in.valid) begin
            product_reg <= MUL_P_W'(op_a * op_b);
        end
    end

    assign rsp_out = rsp_reg;
    assign product = product_reg;

endmodule

`default_nettype wire

[rtl/first_person_camera_step.sv]
// First-person camera step. A load transfer (func = 1) sets the camera position and
// returns it in the cycle after acceptance. A tick transfer (func = 0) applies the yaw
// rule and pitch clamp, looks up sin/cos of yaw and sin of pitch in a five-stage
// table pipeline, forms the clamped speeds and the four position terms on one shared
// multiplier, and returns position, look-at point and effective angles. The four
// position terms on the multiplier wait for the sine pipeline's results. The block
// takes no new item until its result has been transferred out.
`default_nettype none

module first_person_camera_step
    import fpcs_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic signed [15:0] s_yaw_angle,
    input  logic signed [15:0] s_pitch_angle,
    input  logic signed [15:0] s_vel_strafe,
    input  logic signed [15:0] s_vel_forward,
    input  logic        [15:0] s_delta_time,
    input  logic signed [31:0] s_new_x,
    input  logic signed [31:0] s_new_y,
    input  logic signed [31:0] s_new_z,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z,
    output logic signed [31:0] m_look_x,
    output logic signed [31:0] m_look_y,
    output logic signed [31:0] m_look_z,
    output logic signed [15:0] m_yaw_used,
    output logic signed [12:0] m_pitch_used
);

    localparam logic signed [15:0] YAW_LIMIT   = 16'(FULL_TURN);
    localparam logic signed [15:0] PITCH_MAX   = 16'(PITCH_LIMIT);
    localparam logic signed [MUL_P_W-1:0] SPEED_MAX = MUL_P_W'(SPEED_ONE);
    localparam logic signed [MUL_P_W-1:0] ROUND_P   = MUL_P_W'(ROUND_HALF);

    seq_state_t             state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    logic [31:0]            cam_x_reg, cam_y_reg, cam_z_reg;

    logic signed [15:0]     yaw_reg;
    logic signed [12:0]     pitch_reg;
    logic signed [15:0]     vel_f_reg, vel_s_reg;
    logic [15:0]            dt_reg;
    logic signed [SPEED_W-1:0] speed_f_reg, speed_s_reg;
    logic signed [TRIG_W-1:0]  sin_yaw_reg, cos_yaw_reg, sin_pitch_reg;

    logic [31:0]            out_pos_x_reg, out_pos_y_reg, out_pos_z_reg;
    logic [31:0]            out_look_x_reg, out_look_y_reg, out_look_z_reg;
    logic [15:0]            out_yaw_reg;
    logic [12:0]            out_pitch_reg;

    logic                   accept;
    logic                   load_now;
    logic                   result_now;
    logic signed [15:0]     yaw_rule;
    logic signed [15:0]     pitch_clamp;

    trig_req_t                 trig_req, trig_rsp;
    logic signed [ANGLE_W-1:0] trig_angle;
    logic signed [TRIG_W-1:0]  trig_value;

    mul_req_t                  mul_req, mul_rsp;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_product;

    logic signed [MUL_P_W-1:0] speed_clamped;
    logic signed [MUL_P_W-1:0] term_rounded;
    logic signed [MUL_P_W-1:0] term_shifted;
    logic [31:0]               term;

    fpcs_sine #(
        .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
    ) u_sine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_in  (trig_req),
        .angle   (trig_angle),
        .rsp_out (trig_rsp),
        .value   (trig_value)
    );

    fpcs_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_in  (mul_req),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .rsp_out (mul_rsp),
        .product (mul_product)
    );

    // Yaw rule and pitch clamp on the incoming item.
    always_comb begin
        if (s_yaw_angle >= YAW_LIMIT || s_yaw_angle <= -YAW_LIMIT) begin
            yaw_rule = '0;
        end else begin
            yaw_rule = s_yaw_angle;
        end
        if (s_pitch_angle > PITCH_MAX) begin
            pitch_clamp = PITCH_MAX;
        end else if (s_pitch_angle < -PITCH_MAX) begin
            pitch_clamp = -PITCH_MAX;
        end else begin
            pitch_clamp = s_pitch_angle;
        end
    end

    // Speed saturation and the rounded position term from the multiplier output.
    always_comb begin
        if (mul_product > SPEED_MAX) begin
            speed_clamped = SPEED_MAX;
        end else if (mul_product < -SPEED_MAX) begin
            speed_clamped = -SPEED_MAX;
        end else begin
            speed_clamped = mul_product;
        end
        term_rounded = mul_product + ROUND_P;
        term_shifted = term_rounded >>> TERM_SHIFT;
        term         = term_shifted[31:0];
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = (state_reg == ST_IDLE);
        m_valid    = (state_reg == ST_DONE);
        accept     = 1'b0;
        load_now   = 1'b0;
        result_now = 1'b0;
        trig_req   = '{valid: 1'b0, sel: TRIG_SIN_YAW};
        trig_angle = {yaw_reg[15], yaw_reg};
        mul_req    = '{valid: 1'b0, sel: MUL_SPEED_FWD};
        mul_a      = {{(MUL_A_W-16){vel_f_reg[15]}}, vel_f_reg};
        mul_b      = signed'({1'b0, dt_reg});

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    accept    = 1'b1;
                    step_next = '0;
                    if (s_func == FUNC_LOAD) begin
                        load_now   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_BUSY;
                    end
                end
            end
            ST_BUSY: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_RESULT) begin
                    result_now = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg == ST_BUSY) begin
            unique case (step_reg)
                STEP_SIN_YAW: begin
                    trig_req = '{valid: 1'b1, sel: TRIG_SIN_YAW};
                    mul_req  = '{valid: 1'b1, sel: MUL_SPEED_FWD};
                end
                STEP_COS_YAW: begin
                    trig_req   = '{valid: 1'b1, sel: TRIG_COS_YAW};
                    trig_angle = {yaw_reg[15], yaw_reg} + ANGLE_W'(QUARTER_TURN);
                    mul_req    = '{valid: 1'b1, sel: MUL_SPEED_STRAFE};
                    mul_a      = {{(MUL_A_W-16){vel_s_reg[15]}}, vel_s_reg};
                end
                STEP_SIN_PITCH: begin
                    trig_req   = '{valid: 1'b1, sel: TRIG_SIN_PITCH};
                    trig_angle = {{(ANGLE_W-13){pitch_reg[12]}}, pitch_reg};
                end
                STEP_Z_FWD: begin
                    mul_req = '{valid: 1'b1, sel: MUL_STEP_Z};
                    mul_a   = speed_f_reg;
                    mul_b   = {sin_yaw_reg[15], sin_yaw_reg};
                end
                STEP_X_FWD: begin
                    mul_req = '{valid: 1'b1, sel: MUL_STEP_X};
                    mul_a   = speed_f_reg;
                    mul_b   = {cos_yaw_reg[15], cos_yaw_reg};
                end
                STEP_X_STRAFE: begin
                    // Strafe direction is yaw + 90 degrees: cos becomes -sin yaw.
                    mul_req = '{valid: 1'b1, sel: MUL_STEP_X};
                    mul_a   = speed_s_reg;
                    mul_b   = -{sin_yaw_reg[15], sin_yaw_reg};
                end
                STEP_Z_STRAFE: begin
                    mul_req = '{valid: 1'b1, sel: MUL_STEP_Z};
                    mul_a   = speed_s_reg;
                    mul_b   = {cos_yaw_reg[15], cos_yaw_reg};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (load_now) begin
                cam_x_reg <= s_new_x;
                cam_y_reg <= s_new_y;
                cam_z_reg <= s_new_z;
            end else if (mul_rsp.valid && mul_rsp.sel == MUL_STEP_X) begin
                cam_x_reg <= cam_x_reg + term;
            end else if (mul_rsp.valid && mul_rsp.sel == MUL_STEP_Z) begin
                cam_z_reg <= cam_z_reg + term;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            yaw_reg   <= yaw_rule;
            pitch_reg <= pitch_clamp[12:0];
            vel_f_reg <= s_vel_forward;
            vel_s_reg <= s_vel_strafe;
            dt_reg    <= s_delta_time;
        end
        if (trig_rsp.valid) begin
            case (trig_rsp.sel)
                TRIG_SIN_YAW:   sin_yaw_reg   <= trig_value;
                TRIG_COS_YAW:   cos_yaw_reg   <= trig_value;
                default:        sin_pitch_reg <= trig_value;
            endcase
        end
        if (mul_rsp.valid && mul_rsp.sel == MUL_SPEED_FWD) begin
            speed_f_reg <= speed_clamped[SPEED_W-1:0];
        end
        if (mul_rsp.valid && mul_rsp.sel == MUL_SPEED_STRAFE) begin
            speed_s_reg <= speed_clamped[SPEED_W-1:0];
        end
        if (load_now) begin
            out_pos_x_reg  <= s_new_x;
            out_pos_y_reg  <= s_new_y;
            out_pos_z_reg  <= s_new_z;
            out_look_x_reg <= '0;
            out_look_y_reg <= '0;
            out_look_z_reg <= '0;
            out_yaw_reg    <= '0;
            out_pitch_reg  <= '0;
        end else if (result_now) begin
            // Look offsets are Q1.15 doubled into Q16.16.
            out_pos_x_reg  <= cam_x_reg;
            out_pos_y_reg  <= cam_y_reg;
            out_pos_z_reg  <= cam_z_reg;
            out_look_x_reg <= cam_x_reg + {{15{cos_yaw_reg[15]}}, cos_yaw_reg, 1'b0};
            out_look_y_reg <= cam_y_reg + {{15{sin_pitch_reg[15]}}, sin_pitch_reg, 1'b0};
            out_look_z_reg <= cam_z_reg + {{15{sin_yaw_reg[15]}}, sin_yaw_reg, 1'b0};
            out_yaw_reg    <= yaw_reg;
            out_pitch_reg  <= pitch_reg;
        end
    end

    assign m_pos_x      = out_pos_x_reg;
    assign m_pos_y      = out_pos_y_reg;
    assign m_pos_z      = out_pos_z_reg;
    assign m_look_x     = out_look_x_reg;
    assign m_look_y     = out_look_y_reg;
    assign m_look_z     = out_look_z_reg;
    assign m_yaw_used   = out_yaw_reg;
    assign m_pitch_used = out_pitch_reg;

endmodule

`default_nettype wire
